[hw/rtl/dsr_pkg.sv]
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared widths, defaults and the decimal scale table for the decimal
// square root pipeline.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int VALUE_W        = 32;
  localparam int ROOT_W         = 29;
  localparam int DIGITS_W       = 3;
  localparam int MAX_DIGITS_DEF = 4;

  // 10^(2*d): the radicand scale for d fraction digits; any d above 4 gives 10^8
  function automatic logic [63:0] scale_of(input logic [DIGITS_W-1:0] d);
    logic [63:0] s;
    case (d)
      3'd0:    s = 64'd1;
      3'd1:    s = 64'd100;
      3'd2:    s = 64'd10000;
      3'd3:    s = 64'd1000000;
      default: s = 64'd100000000;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/dsr_scale.sv]
// ----------------------------------------------------------------------------
// dsr_scale
// Entry stage: clamps the digit count and multiplies the input magnitude by
// 10^(2*digits). Negative inputs enter the root pipeline as zero.
// ----------------------------------------------------------------------------
module dsr_scale
  import dsr_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int SCALE_W    = 27,
  parameter int RAD_W      = 58
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_vld,
  input  logic [VALUE_W-1:0]  up_value,
  input  logic [DIGITS_W-1:0] digits,
  output logic                dn_vld,
  output logic [RAD_W-1:0]    dn_rad,
  output logic                dn_neg
);

  logic [DIGITS_W-1:0] dig_sel;
  logic [SCALE_W-1:0]  scale_sel;
  logic [VALUE_W-2:0]  mag;
  logic [RAD_W-1:0]    rad_nxt;
  logic                vld_r;
  logic [RAD_W-1:0]    rad_r;
  logic                neg_r;

  // saturate the digit count and pick the scale
  always_comb begin
    dig_sel   = (digits > DIGITS_W'(MAX_DIGITS)) ? DIGITS_W'(MAX_DIGITS) : digits;
    scale_sel = SCALE_W'(scale_of(dig_sel));
    mag       = up_value[VALUE_W-1] ? '0 : up_value[VALUE_W-2:0];
    rad_nxt   = RAD_W'(mag) * RAD_W'(scale_sel);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= up_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    neg_r <= up_value[VALUE_W-1];
  end

  assign dn_vld = vld_r;
  assign dn_rad = rad_r;
  assign dn_neg = neg_r;

endmodule

[hw/rtl/dsr_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// dsr_sqrt_stage
// One registered step of the digit-by-digit square root: brings down two
// radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module dsr_sqrt_stage
  import dsr_pkg::*;
#(
  parameter int RAD_W = 58,
  parameter int RT_W  = 29,
  parameter int REM_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_vld,
  input  logic [RAD_W-1:0] up_rad,
  input  logic [REM_W-1:0] up_rem,
  input  logic [RT_W-1:0]  up_root,
  input  logic             up_neg,
  output logic             dn_vld,
  output logic [RAD_W-1:0] dn_rad,
  output logic [REM_W-1:0] dn_rem,
  output logic [RT_W-1:0]  dn_root,
  output logic             dn_neg
);

  logic [REM_W+1:0] cand;
  logic [REM_W+1:0] trial;
  logic             fit;
  logic [REM_W-1:0] rem_nxt;
  logic [RT_W-1:0]  root_nxt;
  logic             vld_r;
  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [RT_W-1:0]  root_r;
  logic             neg_r;

  // trial subtract of 4*root+1 from the extended remainder
  always_comb begin
    cand     = {up_rem, up_rad[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({up_root, 2'b01});
    fit      = (cand >= trial);
    rem_nxt  = fit ? REM_W'(cand - trial) : REM_W'(cand);
    root_nxt = {up_root[RT_W-2:0], fit};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= up_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rad_r  <= up_rad << 2;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    neg_r  <= up_neg;
  end

  assign dn_vld  = vld_r;
  assign dn_rad  = rad_r;
  assign dn_rem  = rem_r;
  assign dn_root = root_r;
  assign dn_neg  = neg_r;

endmodule

[hw/rtl/decimal_square_root.sv]
// ----------------------------------------------------------------------------
// decimal_square_root
// Pipeline: one scale multiply stage, then one root bit per pipeline stage.
// Throughput: one transaction per cycle; busy stays low, results never wait.
// Reset (synchronous, rst_n low) clears all valid bits and the fraction digit register.
// ----------------------------------------------------------------------------
module decimal_square_root
  import dsr_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root_scaled,
  output logic                out_negative_input,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DIGITS_W-1:0] cfg_data
);

  localparam int SCALE_W = $clog2(scale_of(DIGITS_W'(MAX_DIGITS)) + 64'd1);
  localparam int PROD_W  = VALUE_W - 1 + SCALE_W;
  localparam int RAD_W   = PROD_W + (PROD_W % 2);
  localparam int STAGES  = RAD_W / 2;
  localparam int REM_W   = STAGES + 2;

  logic [DIGITS_W-1:0] digits_r;
  logic                accept;

  logic             vld  [STAGES+1];
  logic [RAD_W-1:0] rad  [STAGES+1];
  logic [REM_W-1:0] rem  [STAGES+1];
  logic [STAGES-1:0] root [STAGES+1];
  logic             neg  [STAGES+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // fraction digit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      digits_r <= cfg_data;
    end
  end

  // scale stage
  dsr_scale #(
    .MAX_DIGITS (MAX_DIGITS),
    .SCALE_W    (SCALE_W),
    .RAD_W      (RAD_W)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (accept),
    .up_value (in_value),
    .digits   (digits_r),
    .dn_vld   (vld[0]),
    .dn_rad   (rad[0]),
    .dn_neg   (neg[0])
  );

  assign rem[0]  = '0;
  assign root[0] = '0;

  // root pipeline, one bit per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    dsr_sqrt_stage #(
      .RAD_W (RAD_W),
      .RT_W  (STAGES),
      .REM_W (REM_W)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (vld[g]),
      .up_rad  (rad[g]),
      .up_rem  (rem[g]),
      .up_root (root[g]),
      .up_neg  (neg[g]),
      .dn_vld  (vld[g+1]),
      .dn_rad  (rad[g+1]),
      .dn_rem  (rem[g+1]),
      .dn_root (root[g+1]),
      .dn_neg  (neg[g+1])
    );
  end

  // result ports
  assign out_valid          = vld[STAGES];
  assign out_root_scaled    = ROOT_W'(root[STAGES]);
  assign out_negative_input = neg[STAGES];

`ifndef SYNTHESIS
  // every accepted transaction yields exactly one strobe after the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(STAGES+1) out_valid)
    else $error("result strobe missing after accepted transaction");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##(STAGES+1) !out_valid)
    else $error("result strobe without a transaction");

  a_neg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(STAGES+1) (out_negative_input == $past(in_value[VALUE_W-1], STAGES+1)))
    else $error("negative flag does not follow input sign");

  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_negative_input) |-> (out_root_scaled == '0))
    else $error("negative input gave a nonzero root");
`endif

endmodule
